// File: rtl/core/hdwt_pkg.sv
// ----------------------------------------------------------------------------
// hdwt_pkg
// Shared constants and types for the one-level 2-D Haar transform.
// ----------------------------------------------------------------------------
package hdwt_pkg;

  localparam int HDWT_MAX_WIDTH  = 1024;
  localparam int HDWT_MAX_HEIGHT = 1024;

  localparam int PIX_W        = 8;
  localparam int PAIRS_W      = 10;
  localparam int PAIRS_RESET  = 512;
  localparam int HALF_W       = 9;
  localparam int QUARTER_W    = 10;
  localparam int INDEX_W      = 9;

  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 96;

  // First field in the highest bits: members listed from the top down.
  typedef struct packed {
    logic        [INDEX_W-1:0]   block_row;
    logic        [INDEX_W-1:0]   block_col;
    logic signed [QUARTER_W-1:0] band_hh;
    logic signed [QUARTER_W-1:0] band_hl;
    logic signed [QUARTER_W-1:0] band_lh;
    logic        [QUARTER_W-1:0] band_ll;
    logic signed [HALF_W-1:0]    high_right;
    logic signed [HALF_W-1:0]    high_left;
    logic        [HALF_W-1:0]    low_right;
    logic        [HALF_W-1:0]    low_left;
  } hdwt_result_t;

  localparam int RESULT_W = $bits(hdwt_result_t);

endpackage

// File: rtl/core/hdwt_ram.sv
// ----------------------------------------------------------------------------
// hdwt_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module hdwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/haar_dwt_2d_one_level_top.sv
// ----------------------------------------------------------------------------
// haar_dwt_2d_one_level_top
// One-level 2-D Haar transform on a raster pixel stream, one result per 2x2.
// ----------------------------------------------------------------------------
// Channel   Dir  Ports               Content
// in        in   in_tdata, in_tuser  pixel; frame_start flag
// out       out  out_tdata           vertical low/high pairs, LL/LH/HL/HH, block index
// cfg       in   cfg_wr_en/_data     pairs_per_row
//
// One pixel per cycle while in_tready is high; the even row sits in two
// column-bank RAMs. After its bottom-right pixel a result goes through the
// RAM read, then the output register. Reset clears position, parity, row
// count and the output valid; RAM contents are not cleared. A stalled output
// with a result waiting in the read stage holds in_tready low.
// ----------------------------------------------------------------------------
module haar_dwt_2d_one_level_top #(
  parameter int MAX_WIDTH  = hdwt_pkg::HDWT_MAX_WIDTH,
  parameter int MAX_HEIGHT = hdwt_pkg::HDWT_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hdwt_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] pixel
  input  logic                               in_tuser,   // [0] frame_start
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [8:0] low_left, [17:9] low_right, [26:18] high_left, [35:27] high_right,
  // [45:36] band_ll, [55:46] band_lh, [65:56] band_hl, [75:66] band_hh,
  // [84:76] block_col, [93:85] block_row, [95:94] zero
  output logic [hdwt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [hdwt_pkg::PAIRS_W-1:0]       cfg_wr_data  // pairs_per_row
);
  import hdwt_pkg::*;

  localparam int HALF_MAX = MAX_WIDTH / 2;
  localparam int ROWS_MAX = MAX_HEIGHT / 2;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int LW  = CW + 1;
  localparam int AW  = (HALF_MAX > 1) ? $clog2(HALF_MAX) : 1;
  localparam int RW  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int PCW = (LW > PAIRS_W) ? LW : PAIRS_W;
  localparam int SW  = PIX_W + 2;

  // ---------------- configuration ----------------
  logic [PAIRS_W-1:0] pairs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pairs_r <= PAIRS_W'(PAIRS_RESET);
    end else if (cfg_wr_en) begin
      pairs_r <= cfg_wr_data;
    end
  end

  logic [PCW-1:0] pairs_ext;
  logic [PCW-1:0] pairs_clamp;
  logic [LW-1:0]  line_w;

  always_comb begin
    pairs_ext = PCW'(pairs_r);
    if (pairs_ext == '0) begin
      pairs_clamp = PCW'(1);
    end else if (pairs_ext > PCW'(HALF_MAX)) begin
      pairs_clamp = PCW'(HALF_MAX);
    end else begin
      pairs_clamp = pairs_ext;
    end
    line_w = LW'(pairs_clamp) << 1;
  end

  // ---------------- position tracking ----------------
  logic [CW-1:0]    col_r, col_nxt;
  logic             odd_r, odd_nxt;
  logic [RW-1:0]    prc_r, prc_nxt;
  logic [PIX_W-1:0] held_bl_r;

  logic [CW-1:0] col_cur;
  logic          odd_cur;
  logic [RW-1:0] prc_cur;
  logic [LW-1:0] col_inc;
  logic [RW:0]   prc_inc;
  logic          accept;
  logic [PIX_W-1:0] pixel;
  logic [AW-1:0] pair_addr;

  assign accept = in_tvalid && in_tready;
  assign pixel  = in_tdata[PIX_W-1:0];

  always_comb begin
    col_cur = in_tuser ? '0 : col_r;
    odd_cur = in_tuser ? 1'b0 : odd_r;
    prc_cur = in_tuser ? '0 : prc_r;
    col_inc = LW'(col_cur) + LW'(1);
    prc_inc = (RW+1)'(prc_cur) + (RW+1)'(1);
    col_nxt = col_inc[CW-1:0];
    odd_nxt = odd_cur;
    prc_nxt = prc_cur;
    if (col_inc >= line_w) begin
      col_nxt = '0;
      odd_nxt = !odd_cur;
      if (odd_cur) begin
        prc_nxt = (prc_inc >= (RW+1)'(ROWS_MAX)) ? '0 : prc_inc[RW-1:0];
      end
    end
  end

  assign pair_addr = AW'(col_cur >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      odd_r <= 1'b0;
      prc_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      odd_r <= odd_nxt;
      prc_r <= prc_nxt;
    end
  end

  // hold the bottom-left pixel of the current block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bl_r <= '0;
    end else if (accept && odd_cur && !col_cur[0]) begin
      held_bl_r <= pixel;
    end
  end

  // ---------------- line buffer, even and odd column banks ----------------
  logic             we_even, we_odd, rd_en;
  logic [PIX_W-1:0] rd_even, rd_odd;

  assign we_even = accept && !odd_cur && !col_cur[0];
  assign we_odd  = accept && !odd_cur &&  col_cur[0];
  assign rd_en   = accept &&  odd_cur &&  col_cur[0];

  hdwt_ram #(.WIDTH(PIX_W), .DEPTH(HALF_MAX), .AW(AW)) u_bank_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (pair_addr),
    .wdata (pixel),
    .re    (rd_en),
    .raddr (pair_addr),
    .rdata (rd_even)
  );

  hdwt_ram #(.WIDTH(PIX_W), .DEPTH(HALF_MAX), .AW(AW)) u_bank_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (pair_addr),
    .wdata (pixel),
    .re    (rd_en),
    .raddr (pair_addr),
    .rdata (rd_odd)
  );

  // ---------------- read stage ----------------
  logic             s1_v_r;
  logic [PIX_W-1:0] s1_bl_r, s1_br_r;
  logic [AW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic             out_v_r;
  hdwt_result_t     out_data_r, res_nxt;
  logic             out_en;

  assign out_en    = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || out_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_bl_r  <= held_bl_r;
      s1_br_r  <= pixel;
      s1_col_r <= pair_addr;
      s1_row_r <= prc_cur;
    end
  end

  logic [SW-1:0] tl, tr, bl, br;

  always_comb begin
    tl = SW'(rd_even);
    tr = SW'(rd_odd);
    bl = SW'(s1_bl_r);
    br = SW'(s1_br_r);
    res_nxt.low_left   = HALF_W'(tl + bl);
    res_nxt.low_right  = HALF_W'(tr + br);
    res_nxt.high_left  = HALF_W'(tl - bl);
    res_nxt.high_right = HALF_W'(tr - br);
    res_nxt.band_ll    = QUARTER_W'(tl + bl + tr + br);
    res_nxt.band_lh    = QUARTER_W'(tl + bl - tr - br);
    res_nxt.band_hl    = QUARTER_W'(tl - bl + tr - br);
    res_nxt.band_hh    = QUARTER_W'(tl - bl - tr + br);
    res_nxt.block_col  = INDEX_W'(s1_col_r);
    res_nxt.block_row  = INDEX_W'(s1_row_r);
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_v_r) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

`ifndef ASSERT_OFF
  // a waiting result in the read stage must block intake while output stalls
  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_tready |-> !in_tready)
    else $error("intake open while read stage is blocked");

  // bottom-right pixel of a block leads to a pending read stage entry
  a_block_issue: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_v_r)
    else $error("block read lost");

  // column position stays inside the line buffer
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(col_r) < LW'(MAX_WIDTH))
    else $error("column position out of range");

  // subband LL equals the sum of the two vertical lowpass values
  a_ll_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_data_r.band_ll ==
      QUARTER_W'(QUARTER_W'(out_data_r.low_left) + QUARTER_W'(out_data_r.low_right)))
    else $error("band_ll mismatch");

  // buffer is never written and read in the same cycle
  a_no_rw: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && (we_even || we_odd)))
    else $error("line buffer write and read together");
`endif

endmodule
